[design/tlp_pkg.sv]
// Package: widths, weight ROM, activation tables and helpers for the perceptron.
package tlp_pkg;

    localparam int FEAT_BITS      = 16;
    localparam int FEAT_COUNT     = 4;
    localparam int ROM_DEPTH      = 31;
    localparam int HIDDEN_DEFAULT = 5;
    localparam int WBITS_DEFAULT  = 16;
    localparam int PROB_BITS      = 16;

    localparam logic signed [15:0] WEIGHT_ROM [ROM_DEPTH] = '{
        16'sd4249, 16'sd9508, -16'sd11266, -16'sd15742, 16'sd8030,
        -16'sd4537, 16'sd10527, -16'sd365, -16'sd13439, 16'sd4214,
        16'sd2360, -16'sd9695, 16'sd6128, 16'sd10748, -16'sd6781,
        -16'sd6864, 16'sd1790, 16'sd387, 16'sd17159, -16'sd2429,
        -16'sd255, 16'sd7970, -16'sd8315, 16'sd14628, 16'sd4310,
        16'sd4368, 16'sd13231, -16'sd4974, -16'sd16103, -16'sd12120,
        -16'sd9847
    };

    // tanh(k/4), Q1.14
    localparam logic [14:0] TANH_TAB [17] = '{
        15'd0, 15'd4013, 15'd7571, 15'd10406, 15'd12478, 15'd13898, 15'd14830,
        15'd15423, 15'd15795, 15'd16024, 15'd16165, 15'd16251, 15'd16303,
        15'd16335, 15'd16354, 15'd16366, 15'd16373
    };

    // sigmoid(k/2), Q0.16
    localparam logic [16:0] SIG_TAB [17] = '{
        17'd32768, 17'd40793, 17'd47911, 17'd53581, 17'd57724, 17'd60565,
        17'd62428, 17'd63615, 17'd64357, 17'd64816, 17'd65097, 17'd65269,
        17'd65374, 17'd65438, 17'd65476, 17'd65500, 17'd65514
    };

    // Weight k rescaled to Q2.(WB-2); indexes past the ROM read zero.
    function automatic logic signed [23:0] weight_at(input int k, input int wb);
        logic signed [31:0] r;
        r = (k < ROM_DEPTH) ? 32'(WEIGHT_ROM[k]) : 32'sd0;
        if (wb >= 16)
            r = r <<< (wb - 16);
        else
            r = (r + (32'sd1 <<< (15 - wb))) >>> (16 - wb);
        return r[23:0];
    endfunction

endpackage

[design/two_layer_perceptron_inference.sv]
// Top level: 4-H-1 perceptron, ten-stage pipeline with valid bits.
//   channel | valid    | stall    | payload
//   in      | in_valid | in_stall | height/distance/speed/offset_feature
//   out     | out_valid| out_stall| probability, fire
// One transfer per cycle sustained while out_stall stays low.
// Stages: products, sum, abs, tanh fetch, tanh interp, products, sum, abs,
// sigmoid fetch, output.
// Reset clears only the valid bits; data registers need none.
// A stage advances when it is empty or the stage after it advances, so a stall
// holds every full stage and nothing is lost or repeated.
module two_layer_perceptron_inference
    import tlp_pkg::*;
#(
    parameter int HIDDEN_COUNT = HIDDEN_DEFAULT,
    parameter int WEIGHT_BITS  = WBITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [FEAT_BITS-1:0] height_feature,
    input  logic signed [FEAT_BITS-1:0] distance_feature,
    input  logic signed [FEAT_BITS-1:0] speed_feature,
    input  logic signed [FEAT_BITS-1:0] offset_feature,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [PROB_BITS-1:0]        probability,
    output logic                        fire
);
    localparam int STAGES = 10;

    logic [STAGES-1:0]   vld_reg;
    logic [STAGES-1:0]   adv;
    logic signed [FEAT_BITS-1:0] feat [FEAT_COUNT];
    logic signed [15:0]  hid [HIDDEN_COUNT];

    assign feat[0] = height_feature;
    assign feat[1] = distance_feature;
    assign feat[2] = speed_feature;
    assign feat[3] = offset_feature;

    // Stage enables: last stage frees on transfer, others ripple back
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || !out_stall;
        for (int s = STAGES - 2; s >= 0; s--)
            adv[s] = !vld_reg[s] || adv[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in_valid;
            for (int s = 1; s < STAGES; s++)
                if (adv[s])
                    vld_reg[s] <= vld_reg[s-1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[STAGES-1];

    // Hidden layer: stages 0..4
    for (genvar j = 0; j < HIDDEN_COUNT; j++)
    begin : g_hid
        tlp_hidden #(.INDEX(j), .WEIGHT_BITS(WEIGHT_BITS)) u_hid
        (
            .clk  (clk),
            .adv  ({adv[4], adv[3], adv[2], adv[1], adv[0] && in_valid}),
            .feat (feat),
            .hid  (hid[j])
        );
    end

    // Output layer: stages 5..9
    tlp_output #(.HIDDEN_COUNT(HIDDEN_COUNT), .WEIGHT_BITS(WEIGHT_BITS)) u_out
    (
        .clk         (clk),
        .adv         ({adv[9], adv[8], adv[7], adv[6], adv[5]}),
        .hid         (hid),
        .probability (probability),
        .fire        (fire)
    );
endmodule

[design/tlp_hidden.sv]
// Hidden neuron: four products, sum, round/clamp, tanh table interpolation.
module tlp_hidden
    import tlp_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int WEIGHT_BITS = WBITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic [4:0]                  adv,
    input  logic signed [FEAT_BITS-1:0] feat [FEAT_COUNT],
    output logic signed [15:0]          hid
);
    localparam int PW = FEAT_BITS + WEIGHT_BITS;
    localparam int AW = PW + 4;
    localparam int FR = WEIGHT_BITS - 2;

    logic signed [PW-1:0] prod_reg [FEAT_COUNT];
    logic signed [AW-1:0] sum_next, sum_reg;
    logic signed [AW-1:0] rnd;
    logic signed [15:0]   x_next;
    logic [14:0]          a_reg;
    logic                 neg_reg, neg2_reg;
    logic [14:0]          base_reg;
    logic signed [16:0]   diff_reg;
    logic [9:0]           fr_reg;
    logic [4:0]           idx;
    logic signed [27:0]   interp;
    logic signed [15:0]   hid_next, hid_reg;

    // Stage 1: products
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < FEAT_COUNT; k++)
                prod_reg[k] <= PW'(feat[k] * weight_at(5 * INDEX + k, WEIGHT_BITS));
        end
    end

    // Stage 2: sum with bias, rounded to Q4.12 and clamped
    always_comb
    begin
        sum_next = AW'(weight_at(5 * INDEX + 4, WEIGHT_BITS)) <<< 12;
        for (int k = 0; k < FEAT_COUNT; k++)
            sum_next = sum_next + AW'(prod_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
            sum_reg <= sum_next;
    end

    always_comb
    begin
        rnd = (sum_reg + (AW'(1) <<< (FR - 1))) >>> FR;
        if (rnd > AW'(16384))
            x_next = 16'sd16384;
        else if (rnd < -AW'(16384))
            x_next = -16'sd16384;
        else
            x_next = rnd[15:0];
    end

    // Stage 3: sign and magnitude; stage 4: table fetch
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            neg_reg  <= x_next[15];
            a_reg    <= x_next[15] ? 15'(-x_next) : x_next[14:0];
        end
    end

    assign idx = a_reg[14:10];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            neg2_reg <= neg_reg;
            if (idx >= 5'd16)
            begin
                base_reg <= TANH_TAB[16];
                diff_reg <= '0;
            end
            else
            begin
                base_reg <= TANH_TAB[idx];
                diff_reg <= 17'(TANH_TAB[idx + 5'd1]) - 17'(TANH_TAB[idx]);
            end
            fr_reg <= a_reg[9:0];
        end
    end

    // Interpolation, registered before the output layer
    assign interp = 28'(diff_reg * $signed({1'b0, fr_reg})) + 28'sd512;
    always_comb
    begin
        logic signed [15:0] y;
        y = 16'(base_reg) + 16'(interp >>> 10);
        hid_next = neg2_reg ? -y : y;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
            hid_reg <= hid_next;
    end

    assign hid = hid_reg;
endmodule

[design/tlp_output.sv]
// Output neuron: products, sum, sigmoid table interpolation.
module tlp_output
    import tlp_pkg::*;
#(
    parameter int HIDDEN_COUNT = HIDDEN_DEFAULT,
    parameter int WEIGHT_BITS  = WBITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic [4:0]           adv,
    input  logic signed [15:0]   hid [HIDDEN_COUNT],
    output logic [PROB_BITS-1:0] probability,
    output logic                 fire
);
    localparam int PW = 16 + WEIGHT_BITS;
    localparam int AW = PW + 6;
    localparam int FR = WEIGHT_BITS;

    logic signed [PW-1:0] prod_reg [HIDDEN_COUNT];
    logic signed [AW-1:0] sum_next, sum_reg, rnd;
    logic signed [16:0]   z_next;
    logic [15:0]          a_reg;
    logic                 neg_reg, neg2_reg, fire_reg, fire2_reg, fire3_reg;
    logic [16:0]          base_reg;
    logic signed [17:0]   diff_reg;
    logic [10:0]          fr_reg;
    logic [4:0]           idx;
    logic signed [29:0]   interp;
    logic signed [18:0]   y, yo;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int j = 0; j < HIDDEN_COUNT; j++)
                prod_reg[j] <= PW'(hid[j] * weight_at(5 * HIDDEN_COUNT + j, WEIGHT_BITS));
        end
    end

    always_comb
    begin
        sum_next = AW'(weight_at(6 * HIDDEN_COUNT, WEIGHT_BITS)) <<< 14;
        for (int j = 0; j < HIDDEN_COUNT; j++)
            sum_next = sum_next + AW'(prod_reg[j]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
            sum_reg <= sum_next;
    end

    always_comb
    begin
        rnd = (sum_reg + (AW'(1) <<< (FR - 1))) >>> FR;
        if (rnd > AW'(32768))
            z_next = 17'sd32768;
        else if (rnd < -AW'(32768))
            z_next = -17'sd32768;
        else
            z_next = rnd[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            neg_reg  <= z_next[16];
            a_reg    <= z_next[16] ? 16'(-z_next) : z_next[15:0];
            fire_reg <= (sum_reg > 0);
        end
    end

    assign idx = a_reg[15:11];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            neg2_reg  <= neg_reg;
            fire2_reg <= fire_reg;
            if (idx >= 5'd16)
            begin
                base_reg <= SIG_TAB[16];
                diff_reg <= '0;
            end
            else
            begin
                base_reg <= SIG_TAB[idx];
                diff_reg <= 18'(SIG_TAB[idx + 5'd1]) - 18'(SIG_TAB[idx]);
            end
            fr_reg <= a_reg[10:0];
        end
    end

    // Interpolate, mirror for negative argument, saturate
    assign interp = 30'(diff_reg * $signed({1'b0, fr_reg})) + 30'sd1024;
    always_comb
    begin
        y  = 19'(base_reg) + 19'(interp >>> 11);
        yo = neg2_reg ? 19'sd65536 - y : y;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            fire3_reg <= fire2_reg;
            if (yo > 19'sd65535)
                probability <= 16'hFFFF;
            else if (yo < 0)
                probability <= '0;
            else
                probability <= yo[15:0];
        end
    end

    assign fire = fire3_reg;
endmodule

[sim/two_layer_perceptron_inference_checker.sv]
// Checker: predicts perceptron results for each input transfer and compares outputs.
`timescale 1ns / 1ps
module two_layer_perceptron_inference_checker
    import tlp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic signed [FEAT_BITS-1:0] height_feature,
    input  logic signed [FEAT_BITS-1:0] distance_feature,
    input  logic signed [FEAT_BITS-1:0] speed_feature,
    input  logic signed [FEAT_BITS-1:0] offset_feature,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [PROB_BITS-1:0]        probability,
    input  logic                        fire,
    output int                          fail_count,
    output int                          pending_count
);

    typedef struct packed {
        logic [PROB_BITS-1:0] prob;
        logic                 fire;
    } score_t;

    localparam longint TANH_PTS [17] = '{0, 4013, 7571, 10406, 12478, 13898, 14830,
        15423, 15795, 16024, 16165, 16251, 16303, 16335, 16354, 16366, 16373};
    localparam longint SIG_PTS [17] = '{32768, 40793, 47911, 53581, 57724, 60565,
        62428, 63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
    localparam longint NET_WEIGHTS [31] = '{
        4249, 9508, -11266, -15742, 8030, -4537, 10527, -365, -13439, 4214,
        2360, -9695, 6128, 10748, -6781, -6864, 1790, 387, 17159, -2429,
        -255, 7970, -8315, 14628, 4310, 4368, 13231, -4974, -16103, -12120, -9847};

    score_t score_queue[$];

    // arithmetic shift right rounds toward minus infinity, so adding half rounds half up
    function automatic longint round_half_up(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    // odd tanh by table, Q4.12 in, Q1.14 out
    function automatic longint tanh_lookup(longint x);
        longint a, y;
        int i;
        x = clamp_mag(x, 16384);
        a = (x < 0) ? -x : x;
        i = int'(a >>> 10);
        if (i >= 16)
            y = TANH_PTS[16];
        else
            y = TANH_PTS[i] + (((TANH_PTS[i+1] - TANH_PTS[i]) * (a & 1023) + 512) >>> 10);
        return (x < 0) ? -y : y;
    endfunction

    // sigmoid by table, Q4.12 in, Q0.16 out with symmetry for negatives
    function automatic longint sigmoid_lookup(longint z);
        longint a, y;
        int i;
        z = clamp_mag(z, 32768);
        a = (z < 0) ? -z : z;
        i = int'(a >>> 11);
        if (i >= 16)
            y = SIG_PTS[16];
        else
            y = SIG_PTS[i] + (((SIG_PTS[i+1] - SIG_PTS[i]) * (a & 2047) + 1024) >>> 11);
        if (z < 0)
            y = 65536 - y;
        if (y > 65535)
            y = 65535;
        return y;
    endfunction

    function automatic score_t infer_score(longint f0, longint f1, longint f2, longint f3);
        longint acc, hid;
        score_t s;
        longint outsum;
        outsum = 0;
        for (int j = 0; j < 5; j++)
        begin
            acc = f0 * NET_WEIGHTS[5*j] + f1 * NET_WEIGHTS[5*j+1]
                + f2 * NET_WEIGHTS[5*j+2] + f3 * NET_WEIGHTS[5*j+3]
                + NET_WEIGHTS[5*j+4] * 4096;
            hid = tanh_lookup(clamp_mag(round_half_up(acc, 14), 16384));
            outsum += hid * NET_WEIGHTS[25+j];
        end
        outsum += NET_WEIGHTS[30] * 16384;
        s.prob = PROB_BITS'(sigmoid_lookup(round_half_up(outsum, 16)));
        s.fire = (outsum > 0);
        return s;
    endfunction

    assign pending_count = score_queue.size();

    // input transfers queue a prediction; output transfers check the oldest
    always @(posedge clk or negedge rst_n)
    begin
        score_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                score_queue.push_back(infer_score(height_feature, distance_feature,
                                                  speed_feature, offset_feature));
            if (out_valid && !out_stall)
            begin
                if (score_queue.size() == 0)
                begin
                    $display("%0t: unexpected result prob=%0d fire=%0d",
                             $time, probability, fire);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = score_queue.pop_front();
                    if (want.prob !== probability || want.fire !== fire)
                    begin
                        $display("%0t: mismatch expected prob=%0d fire=%0d actual prob=%0d fire=%0d",
                                 $time, want.prob, want.fire, probability, fire);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/two_layer_perceptron_inference_tb.sv]
// Testbench top: drives features, stalls the result side and reports the verdict.
`timescale 1ns / 1ps
module two_layer_perceptron_inference_tb;
    import tlp_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic signed [FEAT_BITS-1:0] height_feature = '0;
    logic signed [FEAT_BITS-1:0] distance_feature = '0;
    logic signed [FEAT_BITS-1:0] speed_feature = '0;
    logic signed [FEAT_BITS-1:0] offset_feature = '0;
    logic in_stall, out_valid, fire;
    logic [PROB_BITS-1:0] probability;
    int fail_count, pending_count;
    bit calm_phase = 1'b0;
    bit hold_results = 1'b0;

    always #1 clk = ~clk;

    two_layer_perceptron_inference dut (.*);
    two_layer_perceptron_inference_checker checker_i (.*);

    // one feature: mostly in the active range, sometimes any 16-bit value
    function automatic logic [15:0] pick_feature();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 24576)) - 12288);
        endcase
    endfunction

    // offer one vector and hold it until the transfer happens
    task automatic send_vector(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                               logic [15:0] d, bit may_idle);
        while (may_idle && !calm_phase && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        height_feature <= a;
        distance_feature <= b;
        speed_feature <= c;
        offset_feature <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // result side: random stall, a quiet phase, and a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_results)
            out_stall <= 1'b1;
        else
            out_stall <= !calm_phase && ($urandom_range(0, 99) < 21);
    end

    initial
    begin
        logic [15:0] corner [6];
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: field extremes and saturating sums
        for (int i = 0; i < 6; i++)
            send_vector(corner[i], corner[i], corner[i], corner[i], 1'b0);
        for (int i = 0; i < 16; i++)
            send_vector(i[0] ? 16'h7FFF : 16'h8000, i[1] ? 16'h7FFF : 16'h8000,
                        i[2] ? 16'h7FFF : 16'h8000, i[3] ? 16'h7FFF : 16'h8000, 1'b0);
        // long receiver hold-off while the sender keeps offering
        hold_results <= 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_results <= 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_vector(pick_feature(), pick_feature(), pick_feature(),
                            pick_feature(), 1'b0);
        join
        // sender pause until everything has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        for (int n = 0; n < 1900; n++)
        begin
            calm_phase = (n >= 800 && n < 1000);
            send_vector(pick_feature(), pick_feature(), pick_feature(), pick_feature(), 1'b1);
        end
        calm_phase = 1'b0;
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
design/tlp_pkg.sv
design/tlp_hidden.sv
design/tlp_output.sv
design/two_layer_perceptron_inference.sv
sim/two_layer_perceptron_inference_checker.sv
sim/two_layer_perceptron_inference_tb.sv
